@@ src/rsa_letter_modexp_unit_defines.svh @@
// Assertion macros shared by the checker of the RSA letter exponentiation unit.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef RSA_LETTER_MODEXP_UNIT_DEFINES_SVH
`define RSA_LETTER_MODEXP_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RLM_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RLM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/rlm_pkg.sv @@
// Types, constants and the control store of the RSA letter exponentiation unit.
// Used by rsa_letter_modexp_unit and its checker; depends on nothing.
package rlm_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned RESIDUE_W = 32;
  localparam int unsigned CODE_W = 33;
  localparam int unsigned PC_W = 4;

  localparam logic [VALUE_W-1:0] LETTER_OFFSET = 32'd96;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODULUS = 2'd0,
    CFG_ENC_EXP = 2'd1,
    CFG_DEC_EXP = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
  } op_e;

  typedef struct packed {
    logic               op;
    logic [VALUE_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [RESIDUE_W-1:0] residue;
    logic [CODE_W-1:0]    shifted_code;
  } out_t;

  typedef enum logic [3:0] {
    U_NONE,
    U_ACCEPT,
    U_RED,
    U_FIX,
    U_MUL_AB,
    U_MUL_BB,
    U_ACC_LD,
    U_B_LD_SHR,
    U_ACC_CLR,
    U_EMIT
  } uop_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_N_SMALL,
    C_RED_BUSY,
    C_E_ZERO,
    C_E_LSB0,
    C_E_ONE,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    uop_e            uop;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  localparam logic [PC_W-1:0] ST_IDLE     = 4'd0;
  localparam logic [PC_W-1:0] ST_BASE_RED = 4'd2;
  localparam logic [PC_W-1:0] ST_EXP_TEST = 4'd4;
  localparam logic [PC_W-1:0] ST_MUL_RED  = 4'd7;
  localparam logic [PC_W-1:0] ST_SQUARE   = 4'd9;
  localparam logic [PC_W-1:0] ST_SQ_RED   = 4'd11;
  localparam logic [PC_W-1:0] ST_ZERO     = 4'd13;
  localparam logic [PC_W-1:0] ST_WRITE    = 4'd14;

  // Square-and-multiply program. A taken condition jumps to the target,
  // otherwise the step counter advances by one.
  function automatic ctrl_t ucode_rom(input logic [PC_W-1:0] addr);
    ctrl_t w;
    case (addr)
      4'd0:    w = '{uop: U_ACCEPT,   cond: C_NO_IN,    target: ST_IDLE};
      4'd1:    w = '{uop: U_NONE,     cond: C_N_SMALL,  target: ST_ZERO};
      4'd2:    w = '{uop: U_RED,      cond: C_RED_BUSY, target: ST_BASE_RED};
      4'd3:    w = '{uop: U_FIX,      cond: C_NEVER,    target: ST_IDLE};
      4'd4:    w = '{uop: U_NONE,     cond: C_E_ZERO,   target: ST_WRITE};
      4'd5:    w = '{uop: U_NONE,     cond: C_E_LSB0,   target: ST_SQUARE};
      4'd6:    w = '{uop: U_MUL_AB,   cond: C_NEVER,    target: ST_IDLE};
      4'd7:    w = '{uop: U_RED,      cond: C_RED_BUSY, target: ST_MUL_RED};
      4'd8:    w = '{uop: U_ACC_LD,   cond: C_NEVER,    target: ST_IDLE};
      4'd9:    w = '{uop: U_NONE,     cond: C_E_ONE,    target: ST_WRITE};
      4'd10:   w = '{uop: U_MUL_BB,   cond: C_NEVER,    target: ST_IDLE};
      4'd11:   w = '{uop: U_RED,      cond: C_RED_BUSY, target: ST_SQ_RED};
      4'd12:   w = '{uop: U_B_LD_SHR, cond: C_ALWAYS,   target: ST_EXP_TEST};
      4'd13:   w = '{uop: U_ACC_CLR,  cond: C_NEVER,    target: ST_IDLE};
      4'd14:   w = '{uop: U_EMIT,     cond: C_OUT_BUSY, target: ST_WRITE};
      4'd15:   w = '{uop: U_NONE,     cond: C_ALWAYS,   target: ST_IDLE};
      default: w = '{uop: U_NONE,     cond: C_ALWAYS,   target: ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

@@ src/rsa_letter_modexp_unit.sv @@
// Top level of the RSA letter exponentiation unit: microcoded square-and-multiply.
// Depends on rlm_pkg for payload types, register indexes and the control store.
//
// Usage: an input transaction carries op (0 encrypt a character code, 1 decrypt
// a ciphertext residue) and value. Each input gives exactly one output
// transaction with the residue and the residue plus 96.
// Configuration writes (modulus, encryption and decryption exponents) take
// effect at the clock edge where cfg_we_i is high; they are to be made while
// idle, which the user must keep to, as the block itself does not enforce it.
// One item is in work at a time; in_stall_o is high from the accepting edge
// until the step counter returns to its idle step, and a new item is accepted
// only there. The modular reductions work on a dividend of DW bits, the larger
// of 32 and 2 * MOD_WIDTH, and retire one dividend bit per cycle. A finished
// result waits in the output register while out_stall_i is high; the next item
// is accepted meanwhile and holds in its final step until the register frees.
// Reset clears the step counter and the output valid, and sets modulus 2 and
// both exponents 1.
module rsa_letter_modexp_unit #(
  parameter int unsigned MOD_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rlm_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [rlm_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  rlm_pkg::in_t                        in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output rlm_pkg::out_t                       out_data_o
);
  import rlm_pkg::*;

  localparam int unsigned MW = MOD_WIDTH;
  localparam int unsigned DW = (2 * MW > VALUE_W) ? 2 * MW : VALUE_W;
  localparam int unsigned CW = $clog2(DW);

  logic [MW-1:0]         modulus_q;
  logic [CFG_DATA_W-1:0] enc_exp_q;
  logic [CFG_DATA_W-1:0] dec_exp_q;

  logic [PC_W-1:0]       pc_q, pc_d;
  ctrl_t                 ctrl;
  logic                  take;

  logic [MW-1:0]         acc_q;
  logic [MW-1:0]         b_q;
  logic [MW-1:0]         rem_q;
  logic [DW-1:0]         x_q;
  logic [CW-1:0]         cnt_q;
  logic [CFG_DATA_W-1:0] exp_q;
  logic                  neg_q;

  logic                  out_valid_q;
  logic [MW-1:0]         out_res_q;

  logic                  out_busy;
  logic                  n_small;
  logic [MW:0]           sh;
  logic [MW-1:0]         rem_next;
  logic [VALUE_W-1:0]    diff;
  logic                  below;
  logic [2*MW-1:0]       prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= MW'(2);
      enc_exp_q <= CFG_DATA_W'(1);
      dec_exp_q <= CFG_DATA_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODULUS: modulus_q <= cfg_data_i[MW-1:0];
        CFG_ENC_EXP: enc_exp_q <= cfg_data_i;
        CFG_DEC_EXP: dec_exp_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_busy = out_valid_q && out_stall_i;
  assign n_small = modulus_q < MW'(2);
  assign in_stall_o = (pc_q != ST_IDLE);

  always_comb begin
    ctrl = ucode_rom(pc_q);
    case (ctrl.cond)
      C_NEVER:    take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NO_IN:    take = !in_valid_i;
      C_N_SMALL:  take = n_small;
      C_RED_BUSY: take = (cnt_q != '0);
      C_E_ZERO:   take = (exp_q == '0);
      C_E_LSB0:   take = !exp_q[0];
      C_E_ONE:    take = (exp_q[CFG_DATA_W-1:1] == '0);
      C_OUT_BUSY: take = out_busy;
      default:    take = 1'b0;
    endcase
    pc_d = take ? ctrl.target : pc_q + PC_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= ST_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign below = in_data_i.value < LETTER_OFFSET;
  assign diff = (in_data_i.op == OP_DECRYPT) ? in_data_i.value :
                below ? (LETTER_OFFSET - in_data_i.value) :
                        (in_data_i.value - LETTER_OFFSET);
  assign sh = {rem_q, x_q[DW-1]};
  assign rem_next = (sh >= (MW + 1)'(modulus_q)) ? MW'(sh - (MW + 1)'(modulus_q)) : sh[MW-1:0];
  assign prod = (ctrl.uop == U_MUL_BB) ? b_q * b_q : acc_q * b_q;

  always_ff @(posedge clk_i) begin
    case (ctrl.uop)
      U_ACCEPT: begin
        if (in_valid_i) begin
          x_q   <= DW'(diff);
          rem_q <= '0;
          cnt_q <= CW'(DW - 1);
          neg_q <= (in_data_i.op == OP_ENCRYPT) && below;
          exp_q <= (in_data_i.op == OP_DECRYPT) ? dec_exp_q : enc_exp_q;
        end
      end
      U_RED: begin
        rem_q <= rem_next;
        x_q   <= {x_q[DW-2:0], 1'b0};
        cnt_q <= cnt_q - CW'(1);
      end
      U_FIX: begin
        b_q   <= (neg_q && rem_q != '0) ? modulus_q - rem_q : rem_q;
        acc_q <= MW'(1);
      end
      U_MUL_AB, U_MUL_BB: begin
        x_q   <= DW'(prod);
        rem_q <= '0;
        cnt_q <= CW'(DW - 1);
      end
      U_ACC_LD:   acc_q <= rem_q;
      U_B_LD_SHR: begin
        b_q   <= rem_q;
        exp_q <= {1'b0, exp_q[CFG_DATA_W-1:1]};
      end
      U_ACC_CLR:  acc_q <= '0;
      U_EMIT: begin
        if (!out_busy) begin
          out_res_q <= acc_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.uop == U_EMIT && !out_busy) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o.residue = RESIDUE_W'(out_res_q);
  assign out_data_o.shifted_code = CODE_W'(out_res_q) + CODE_W'(LETTER_OFFSET);

endmodule

@@ src/rlm_checker.sv @@
// Port-level checker for rsa_letter_modexp_unit, attached by the bind below.
// Depends on rlm_pkg and the assertion macros in rsa_letter_modexp_unit_defines.svh.
`include "rsa_letter_modexp_unit_defines.svh"

module rlm_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input rlm_pkg::out_t                  out_data_o
);
  import rlm_pkg::*;

  `RLM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "output transaction dropped while stalled")
  `RLM_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_data_o), "output payload changed while stalled")
  `RLM_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "second transaction accepted while one is in work")
  `RLM_ASSERT_SAME(a_code_sum, clk_i, rst_ni, out_valid_o, out_data_o.shifted_code == CODE_W'(out_data_o.residue) + CODE_W'(LETTER_OFFSET), "shifted code does not match residue")

endmodule

bind rsa_letter_modexp_unit rlm_checker u_rlm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
